// ===== rtl/core/gsps_pkg.sv =====
`default_nettype none

package gsps_pkg;

    // Field widths
    localparam int PIX_W  = 12;   // pixel coordinate
    localparam int POS_W  = 16;   // Q12.4 position
    localparam int LVL_W  = 16;   // Q4.12 level / opacity
    localparam int BYTE_W = 8;
    localparam int COV_W  = 16;   // Q4.12 coverage

    // Sizing constants
    localparam int MAX_DIM        = 4096;
    localparam int EXP_TABLE_SIZE = 256;

    // Squared radius and exponent argument
    localparam int SQ_W      = 2 * POS_W;          // one squared offset, Q.8
    localparam int R2_W      = SQ_W + 1;           // sum of two squares
    localparam int ARG_W     = 12;                 // exponent argument, Q.8, below 16.0
    localparam int ARG_SH    = 8;                  // r2 scaled to Q.8 argument
    localparam int LIMIT_SH  = ARG_W + 1 - ARG_SH; // r2 >= s2 << LIMIT_SH flushes to zero
    localparam int DEN_W     = SQ_W + 1;           // 2 * sigma^2
    localparam int REM_W     = DEN_W + ARG_W;      // divider partial remainder
    localparam int CFG_IDX_W = 3;

    // Exponential table
    localparam int EXP_W     = 17;                 // Q1.16, first entry is 1.0
    localparam int EXP_IDX_W = $clog2(EXP_TABLE_SIZE);
    localparam int EXP_AW    = $clog2(EXP_TABLE_SIZE + 1);
    localparam int LERP_W    = 12;                 // interpolation fraction, Q.12
    localparam int POS_IDX_W = ARG_W + EXP_IDX_W;  // argument times table size

    // Color
    localparam int CH_W     = LVL_W + COV_W;       // level * coverage, Q.24
    localparam int ONE_Q24  = 1 << 24;
    localparam int CLAMP_W  = 25;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_SPREAD   = 3'd2,
        CFG_RED      = 3'd3,
        CFG_GREEN    = 3'd4,
        CFG_BLUE     = 3'd5,
        CFG_OPACITY  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [POS_W-1:0] center_x;
        logic [POS_W-1:0] center_y;
        logic [POS_W-1:0] spread;
        logic [LVL_W-1:0] red_level;
        logic [LVL_W-1:0] green_level;
        logic [LVL_W-1:0] blue_level;
        logic [LVL_W-1:0] opacity;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        center_x:    16'd0,
        center_y:    16'd0,
        spread:      16'd16,
        red_level:   16'd4096,
        green_level: 16'd4096,
        blue_level:  16'd4096,
        opacity:     16'd4096
    };

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } t_pix_item;

    typedef struct packed {
        logic [BYTE_W-1:0] red_byte;
        logic [BYTE_W-1:0] green_byte;
        logic [BYTE_W-1:0] blue_byte;
        logic [COV_W-1:0]  coverage;
    } t_shade_item;

    // Divider result: argument quotient and the flush-to-zero flag
    typedef struct packed {
        logic             over;
        logic [ARG_W-1:0] quot;
    } t_arg_item;

    typedef logic [EXP_TABLE_SIZE:0][EXP_W-1:0] t_exp_tab;

    // Build exp(-k * 16 / size) samples: Taylor series for one step, then powers
    function automatic t_exp_tab build_exp_tab();
        t_exp_tab        tab;
        longint unsigned q;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned acc;
        tab  = '0;
        q    = (64'd1 << 36) / EXP_TABLE_SIZE;
        term = 64'd1 << 32;
        sum  = term;
        acc  = term;
        for (int n = 1; n < 14; n++) begin
            term = ((term * q) >> 32) / 64'(n);
            if (n[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        for (int i = 0; i <= EXP_TABLE_SIZE; i++) begin
            tab[i] = EXP_W'(acc >> 16);
            acc    = (acc * sum) >> 32;
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

// ===== rtl/core/gsps_front.sv =====
`default_nettype none

module gsps_front
    import gsps_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_vld,
    input  wire t_pix_item        i_pix,
    input  wire t_cfg             i_cfg,
    output logic                  o_vld,
    output logic [R2_W-1:0]       o_r2
);

    logic              r_vld1, r_vld2, r_vld3;
    logic [POS_W-1:0]  r_dx, r_dy;
    logic [SQ_W-1:0]   r_dx2, r_dy2;
    logic [R2_W-1:0]   r_r2;

    logic [PIX_W-1:0]  sat_x, sat_y;
    logic [POS_W-1:0]  px, py, n_dx, n_dy;

    // Clamp coordinates to the raster and form pixel centers in Q12.4
    always_comb begin
        sat_x = ((PIX_W+1)'(i_pix.pixel_x) >= (PIX_W+1)'(MAX_DIM))
              ? PIX_W'(MAX_DIM - 1) : i_pix.pixel_x;
        sat_y = ((PIX_W+1)'(i_pix.pixel_y) >= (PIX_W+1)'(MAX_DIM))
              ? PIX_W'(MAX_DIM - 1) : i_pix.pixel_y;
        px    = {sat_x, 4'b1000};
        py    = {sat_y, 4'b1000};
        n_dx  = (px >= i_cfg.center_x) ? px - i_cfg.center_x : i_cfg.center_x - px;
        n_dy  = (py >= i_cfg.center_y) ? py - i_cfg.center_y : i_cfg.center_y - py;
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    // Offsets, squares, squared radius
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_dx2 <= r_dx * r_dx;
            r_dy2 <= r_dy * r_dy;
            r_r2  <= R2_W'(r_dx2) + R2_W'(r_dy2);
        end
    end

    assign o_vld = r_vld3;
    assign o_r2  = r_r2;

endmodule

`default_nettype wire

// ===== rtl/core/gsps_div.sv =====
`default_nettype none

module gsps_div
    import gsps_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_vld,
    input  wire logic [R2_W-1:0]  i_r2,
    input  wire logic [SQ_W-1:0]  i_s2,
    output logic                  o_vld,
    output t_arg_item             o_arg
);

    logic             r_vld  [ARG_W];
    logic [ARG_W-1:0] r_quo  [ARG_W];
    logic             r_over [ARG_W];
    logic [REM_W-1:0] r_rem  [ARG_W-1];

    logic [REM_W-1:0] den_ext;

    assign den_ext = REM_W'({i_s2, 1'b0});

    // One restoring step per stage, quotient bit from the top down
    for (genvar j = 0; j < ARG_W; j++) begin : g_stage
        localparam int SH = ARG_W - 1 - j;

        logic [REM_W-1:0] rem_in, trial;
        logic [ARG_W-1:0] quo_in, quo_nx;
        logic             over_in, vld_in, fit;

        if (j == 0) begin : g_head
            assign rem_in  = REM_W'({i_r2, {ARG_SH{1'b0}}});
            assign quo_in  = '0;
            assign over_in = (R2_W+LIMIT_SH)'(i_r2) >= {1'b0, i_s2, {LIMIT_SH{1'b0}}};
            assign vld_in  = i_vld;
        end else begin : g_body
            assign rem_in  = r_rem[j-1];
            assign quo_in  = r_quo[j-1];
            assign over_in = r_over[j-1];
            assign vld_in  = r_vld[j-1];
        end

        assign trial  = den_ext << SH;
        assign fit    = rem_in >= trial;
        assign quo_nx = quo_in | (ARG_W'(fit) << SH);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[j]  <= quo_nx;
                r_over[j] <= over_in;
            end
        end

        // Keep the remainder only where a later step needs it
        if (j < ARG_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= fit ? rem_in - trial : rem_in;
                end
            end
        end
    end

    assign o_vld      = r_vld[ARG_W-1];
    assign o_arg.quot = r_quo[ARG_W-1];
    assign o_arg.over = r_over[ARG_W-1];

endmodule

`default_nettype wire

// ===== rtl/core/gsps_exp.sv =====
`default_nettype none

module gsps_exp
    import gsps_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_vld,
    input  wire t_arg_item        i_arg,
    input  wire t_cfg             i_cfg,
    output logic                  o_vld,
    output logic [COV_W-1:0]      o_cov
);

    logic                    r_vld1, r_vld2, r_vld3, r_vld4;
    logic [EXP_W-1:0]        r_a1, r_a2;
    logic [EXP_W-1:0]        r_diff;
    logic [LERP_W-1:0]       r_frac;
    logic                    r_over1, r_over2;
    logic [EXP_W+LERP_W-1:0] r_prod;
    logic [EXP_W-1:0]        r_g;
    logic [COV_W-1:0]        r_cov;

    logic [POS_IDX_W-1:0]    pos;
    logic [EXP_AW-1:0]       idx;
    logic [EXP_W-1:0]        tab_a, tab_b, n_diff;
    logic [EXP_W-1:0]        n_g;
    logic [LVL_W+EXP_W-1:0]  wt;

    // Table position and the two neighbor samples
    always_comb begin
        pos    = POS_IDX_W'(i_arg.quot) * POS_IDX_W'(EXP_TABLE_SIZE);
        idx    = EXP_AW'(pos[POS_IDX_W-1:LERP_W]);
        tab_a  = EXP_TAB[idx];
        tab_b  = EXP_TAB[idx + EXP_AW'(1)];
        n_diff = (tab_a >= tab_b) ? tab_a - tab_b : '0;
    end

    // Interpolate, flush to zero past the table, weight by opacity
    always_comb begin
        n_g = r_over2 ? '0 : r_a2 - r_prod[EXP_W+LERP_W-1:LERP_W];
        wt  = i_cfg.opacity * r_g;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a1    <= tab_a;
            r_diff  <= n_diff;
            r_frac  <= pos[LERP_W-1:0];
            r_over1 <= i_arg.over;
            r_a2    <= r_a1;
            r_prod  <= r_diff * r_frac;
            r_over2 <= r_over1;
            r_g     <= n_g;
            r_cov   <= wt[COV_W+15:16];
        end
    end

    assign o_vld = r_vld4;
    assign o_cov = r_cov;

endmodule

`default_nettype wire

// ===== rtl/core/gsps_color.sv =====
`default_nettype none

module gsps_color
    import gsps_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_vld,
    input  wire logic [COV_W-1:0] i_cov,
    input  wire t_cfg             i_cfg,
    output logic                  o_vld,
    output t_shade_item           o_item
);

    logic              r_vld1, r_vld2;
    logic [CH_W-1:0]   r_cr, r_cg, r_cb;
    logic [COV_W-1:0]  r_cov1;
    t_shade_item       r_item;

    // Clamp a Q.24 channel to 1.0 and scale to a byte
    function automatic logic [BYTE_W-1:0] to_byte(input logic [CH_W-1:0] c);
        logic [CLAMP_W-1:0] cc;
        logic [CH_W:0]      m;
        cc = (c > CH_W'(ONE_Q24)) ? CLAMP_W'(ONE_Q24) : c[CLAMP_W-1:0];
        m  = {cc, 8'b0} - (CH_W+1)'(cc);
        return m[CH_W-1:CH_W-BYTE_W];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    // Composite over black, then clamp and quantize
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cr              <= i_cfg.red_level * i_cov;
            r_cg              <= i_cfg.green_level * i_cov;
            r_cb              <= i_cfg.blue_level * i_cov;
            r_cov1            <= i_cov;
            r_item.red_byte   <= to_byte(r_cr);
            r_item.green_byte <= to_byte(r_cg);
            r_item.blue_byte  <= to_byte(r_cb);
            r_item.coverage   <= r_cov1;
        end
    end

    assign o_vld  = r_vld2;
    assign o_item = r_item;

endmodule

`default_nettype wire

// ===== rtl/core/gaussian_splat_pixel_shader.sv =====
`default_nettype none

// Isotropic Gaussian splat shader: one pixel coordinate in, one shaded pixel
// out (RGB bytes and Q4.12 coverage). It sustains one item per clock while the
// skid register is free; its latency is set mostly by the 12-stage restoring
// divider that forms the exponent argument r2 / (2 sigma^2). Behind the last
// stage sit an output register and a one-entry skid register. When the output
// stalls, the pipeline keeps moving and taking items until a finished item
// lands in the skid register; ready then drops until the skid drains. Write
// registers only while the pipeline is empty; sigma squared is registered from
// the stored spread in the cycle after it is written.
module gaussian_splat_pixel_shader
    import gsps_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire t_pix_item            i_pixel,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output t_shade_item               o_shade,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [LVL_W-1:0]     i_cfg_data
);

    t_cfg              r_cfg;
    logic [SQ_W-1:0]   r_s2;
    logic              r_out_vld, r_skid_vld;
    t_shade_item       r_out, r_skid;

    logic              en, take;
    logic [POS_W-1:0]  sig;
    logic              fr_vld, dv_vld, ex_vld, co_vld;
    logic [R2_W-1:0]   fr_r2;
    t_arg_item         dv_arg;
    logic [COV_W-1:0]  ex_cov;
    t_shade_item       co_item;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_X: r_cfg.center_x    <= i_cfg_data;
                CFG_CENTER_Y: r_cfg.center_y    <= i_cfg_data;
                CFG_SPREAD:   r_cfg.spread      <= i_cfg_data;
                CFG_RED:      r_cfg.red_level   <= i_cfg_data;
                CFG_GREEN:    r_cfg.green_level <= i_cfg_data;
                CFG_BLUE:     r_cfg.blue_level  <= i_cfg_data;
                CFG_OPACITY:  r_cfg.opacity     <= i_cfg_data;
                default:      r_cfg             <= r_cfg;
            endcase
        end
    end

    // Sigma squared, zero spread taken as the smallest step
    assign sig = (r_cfg.spread == '0) ? POS_W'(1) : r_cfg.spread;

    always_ff @(posedge i_clk) begin
        r_s2 <= sig * sig;
    end

    // Whole pipeline advances while the skid register is free
    assign en      = !r_skid_vld;
    assign o_ready = en;
    assign take    = en && co_vld;

    gsps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_valid),
        .i_pix   (i_pixel),
        .i_cfg   (r_cfg),
        .o_vld   (fr_vld),
        .o_r2    (fr_r2)
    );

    gsps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (fr_vld),
        .i_r2    (fr_r2),
        .i_s2    (r_s2),
        .o_vld   (dv_vld),
        .o_arg   (dv_arg)
    );

    gsps_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (dv_vld),
        .i_arg   (dv_arg),
        .i_cfg   (r_cfg),
        .o_vld   (ex_vld),
        .o_cov   (ex_cov)
    );

    gsps_color u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (ex_vld),
        .i_cov   (ex_cov),
        .i_cfg   (r_cfg),
        .o_vld   (co_vld),
        .o_item  (co_item)
    );

    // Output register with skid: drain skid first, else take from the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_ready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= take;
            end
        end else if (take) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_ready) begin
            r_out <= r_skid_vld ? r_skid : co_item;
        end else if (take) begin
            r_skid <= co_item;
        end
    end

    assign o_valid = r_out_vld;
    assign o_shade = r_out;

    // Skid holds an item only behind a waiting output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid item without output item");

    // Stalled skid keeps its item
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !i_ready) |=> (r_skid_vld && $stable(r_skid)))
        else $error("skid item lost during stall");

    // Zero coverage gives black
    a_black_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_shade.coverage == '0) |->
        (o_shade.red_byte == '0 && o_shade.green_byte == '0 &&
         o_shade.blue_byte == '0))
        else $error("color without coverage");

endmodule

`default_nettype wire
